>>> rtl/core/tzadj_pkg.sv
package tzadj_pkg;

  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned OFS_W   = 5;
  localparam int unsigned HSUM_W  = 7;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0]  DAY_FIRST  = 5'd1;
  localparam logic [DAY_W-1:0]  DAY_DEC_31 = 5'd31;
  localparam logic [WDAY_W-1:0] WDAY_FIRST = 3'd1;
  localparam logic [WDAY_W-1:0] WDAY_LAST  = 3'd7;
  localparam logic [YEAR_W-1:0] YEAR_FLOOR = 16'd2000;

  localparam logic signed [HSUM_W-1:0] HOURS_PER_DAY = 7'sd24;

  // floor(y / 25) = (y * DIV25_MAGIC) >> DIV25_SHIFT, exact for 16-bit y
  localparam int unsigned DIV25_MAGIC = 83887;
  localparam int unsigned DIV25_SHIFT = 21;
  localparam int unsigned PROD_W      = 33;
  localparam int unsigned Q25_W       = 12;

  typedef struct packed {
    logic [YEAR_W-1:0]  in_year;
    logic [MONTH_W-1:0] in_month;
    logic [DAY_W-1:0]   in_day;
    logic [HOUR_W-1:0]  in_hour;
    logic [WDAY_W-1:0]  in_weekday;
  } in_item_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  out_year;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;
    logic [HOUR_W-1:0]  out_hour;
    logic [WDAY_W-1:0]  out_weekday;
  } out_item_t;

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [DAY_W-1:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd2:                                       d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      default:                                    d = 5'd30;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/core/timezone_offset_date_adjust.sv
// An accepted transaction passes the s1, s2 and output registers before its out_valid strobe.
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// Stages: offset add and divide-by-25 multiply, leap test and hour wrap, date step.
// Reset (rst_n low, synchronous): pipeline valid bits clear, offset returns to 0.
// The receiver cannot stall: each result is shown for exactly one cycle.
module timezone_offset_date_adjust
  import tzadj_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic signed [OFS_W-1:0] cfg_wdata,
  input  logic                    start,
  output logic                    busy,
  input  in_item_t                in_data,
  output logic                    out_valid,
  output out_item_t               out_data
);

  logic signed [OFS_W-1:0] tz_off_r;

  logic                     s1_v_r;
  in_item_t                 s1_item_r;
  logic signed [HSUM_W-1:0] s1_h_r;
  logic [Q25_W-1:0]         s1_q25_r;

  logic              s2_v_r;
  in_item_t          s2_item_r;
  logic [HOUR_W-1:0] s2_hour_r;
  logic              s2_back_r;
  logic              s2_fwd_r;
  logic              s2_leap_r;

  logic      out_v_r;
  out_item_t out_r;

  logic                     accept;
  logic [PROD_W-1:0]        prod;
  logic signed [HSUM_W-1:0] h_nxt;
  logic [YEAR_W-1:0]        q25x;
  logic [YEAR_W-1:0]        r25;
  logic                     leap_nxt;
  logic                     back_nxt;
  logic                     fwd_nxt;
  logic signed [HSUM_W-1:0] hw;
  out_item_t                out_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tz_off_r <= '0;
    end else if (cfg_we) begin
      tz_off_r <= cfg_wdata;
    end
  end

  // stage 1: offset add, reciprocal multiply for year / 25
  assign prod  = PROD_W'(in_data.in_year) * PROD_W'(DIV25_MAGIC);
  assign h_nxt = $signed({2'b00, in_data.in_hour}) + HSUM_W'(tz_off_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= in_data;
    s1_h_r    <= h_nxt;
    s1_q25_r  <= prod[DIV25_SHIFT+Q25_W-1:DIV25_SHIFT];
  end

  // stage 2: leap test, hour wrap
  always_comb begin
    q25x     = YEAR_W'({s1_q25_r, 4'b0000}) + YEAR_W'({s1_q25_r, 3'b000})
             + YEAR_W'(s1_q25_r);
    r25      = s1_item_r.in_year - q25x;
    leap_nxt = (s1_item_r.in_year[1:0] == 2'b00)
             && ((r25 != '0) || (s1_item_r.in_year[3:0] == 4'b0000));
    back_nxt = s1_h_r < 0;
    fwd_nxt  = s1_h_r >= HOURS_PER_DAY;
    if (back_nxt) begin
      hw = s1_h_r + HOURS_PER_DAY;
    end else if (fwd_nxt) begin
      hw = s1_h_r - HOURS_PER_DAY;
    end else begin
      hw = s1_h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_item_r <= s1_item_r;
    s2_hour_r <= hw[HOUR_W-1:0];
    s2_back_r <= back_nxt;
    s2_fwd_r  <= fwd_nxt;
    s2_leap_r <= leap_nxt;
  end

  // stage 3: step the date one day back or forward when the hour wrapped; Jan 1 of YEAR_FLOOR or earlier is held
  always_comb begin
    logic wvalid;
    logic clamp;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
    logic [YEAR_W-1:0]  y;
    logic [WDAY_W-1:0]  w;
    y      = s2_item_r.in_year;
    m      = s2_item_r.in_month;
    d      = s2_item_r.in_day;
    w      = s2_item_r.in_weekday;
    wvalid = (w != '0);
    clamp  = 1'b0;
    if (s2_back_r) begin
      if (d > DAY_FIRST) begin
        d = d - DAY_FIRST;
      end else if (m > MONTH_JAN) begin
        m = m - MONTH_JAN;
        d = days_in_month(m, s2_leap_r);
      end else if (y > YEAR_FLOOR) begin
        m = MONTH_DEC;
        y = y - YEAR_W'(1);
        d = DAY_DEC_31;
      end else begin
        clamp = 1'b1;
      end
      if (wvalid && !clamp) begin
        w = (w == WDAY_FIRST) ? WDAY_LAST : w - WDAY_W'(1);
      end
    end else if (s2_fwd_r) begin
      if (d < days_in_month(m, s2_leap_r)) begin
        d = d + DAY_W'(1);
      end else begin
        d = DAY_FIRST;
        if (m < MONTH_DEC) begin
          m = m + MONTH_W'(1);
        end else begin
          m = MONTH_JAN;
          y = y + YEAR_W'(1);
        end
      end
      if (wvalid) begin
        w = (w == WDAY_LAST) ? WDAY_FIRST : w + WDAY_W'(1);
      end
    end
    out_nxt.out_year    = y;
    out_nxt.out_month   = m;
    out_nxt.out_day     = d;
    out_nxt.out_hour    = s2_hour_r;
    out_nxt.out_weekday = w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

>>> rtl/core/tzadj_checker.sv
module tzadj_checker
  import tzadj_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_data,
  input logic      out_valid,
  input out_item_t out_data
);

  // one strobe per accepted transaction, after the pipeline registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1))
      |-> (out_valid == $past(start && !busy, 3)))
    else $error("result strobe does not follow transaction by three cycles");

  a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_hour < 5'd24))
    else $error("hour out of range");

  a_wday_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start && !busy, 3) && ($past(in_data.in_weekday, 3) == '0))
      |-> (out_data.out_weekday == '0))
    else $error("weekday zero not passed through");

  a_wday_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start && !busy, 3) && ($past(in_data.in_weekday, 3) != '0))
      |-> (out_data.out_weekday != '0))
    else $error("valid weekday turned to zero");

  a_day_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start && !busy, 3) && ($past(in_data.in_day, 3) != '0))
      |-> (out_data.out_day != '0))
    else $error("day became zero");

endmodule

bind timezone_offset_date_adjust tzadj_checker u_tzadj_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tzadj_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  class date_adjust_scoreboard;
    out_item_t               expected_dates[$];
    logic signed [OFS_W-1:0] hour_shift;
    int                      errors;

    function new();
      hour_shift = '0;
      errors     = 0;
    endfunction

    function void set_offset(logic signed [OFS_W-1:0] v);
      hour_shift = v;
    endfunction

    function bit leap_year(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function int unsigned month_length(int unsigned y, int unsigned m);
      int unsigned len;
      case (m)
        1, 3, 5, 7, 8, 10, 12: len = 31;
        2:                     len = leap_year(y) ? 29 : 28;
        default:               len = 30;
      endcase
      return len;
    endfunction

    function out_item_t shift_date(in_item_t a);
      out_item_t   r;
      int          h;
      int unsigned y;
      int unsigned m;
      int unsigned d;
      logic [WDAY_W-1:0] w;
      bit          rotate;
      y      = a.in_year;
      m      = a.in_month;
      d      = a.in_day;
      w      = a.in_weekday;
      h      = int'(a.in_hour) + int'(hour_shift);
      rotate = (w != '0);
      if (h < 0) begin
        h += 24;
        if (d > DAY_FIRST) begin
          d--;
        end else if (m > MONTH_JAN) begin
          m--;
          d = month_length(y, m);
        end else if (y > YEAR_FLOOR) begin
          m = MONTH_DEC;
          y--;
          d = month_length(y, m);
        end else begin
          rotate = 1'b0;
        end
        if (rotate) w = (w == WDAY_FIRST) ? WDAY_LAST : w - 1'b1;
      end else if (h >= 24) begin
        h -= 24;
        if (d < month_length(y, m)) begin
          d++;
        end else begin
          d = DAY_FIRST;
          if (m < MONTH_DEC) begin
            m++;
          end else begin
            m = MONTH_JAN;
            y = (y + 1) & 32'hFFFF;
          end
        end
        if (rotate) w = (w == WDAY_LAST) ? WDAY_FIRST : w + 1'b1;
      end
      r.out_year    = y[YEAR_W-1:0];
      r.out_month   = m[MONTH_W-1:0];
      r.out_day     = d[DAY_W-1:0];
      r.out_hour    = h[HOUR_W-1:0];
      r.out_weekday = w;
      return r;
    endfunction

    function void note_input(in_item_t a);
      expected_dates.push_back(shift_date(a));
    endfunction

    function void compare_field(string field, int unsigned e, int unsigned g);
      if (e != g) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, e, g);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_date;
      if (expected_dates.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %0d-%0d-%0d h%0d w%0d",
                 $time, got.out_year, got.out_month, got.out_day, got.out_hour,
                 got.out_weekday);
        errors++;
        return;
      end
      exp_date = expected_dates.pop_front();
      compare_field("out_year", exp_date.out_year, got.out_year);
      compare_field("out_month", exp_date.out_month, got.out_month);
      compare_field("out_day", exp_date.out_day, got.out_day);
      compare_field("out_hour", exp_date.out_hour, got.out_hour);
      compare_field("out_weekday", exp_date.out_weekday, got.out_weekday);
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic signed [OFS_W-1:0] cfg_wdata;
  logic                    start;
  logic                    busy;
  in_item_t                in_data;
  logic                    out_valid;
  out_item_t               out_data;

  date_adjust_scoreboard sb;
  int                    cycle_count;

  timezone_offset_date_adjust uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  function automatic in_item_t make_date(int unsigned y, int unsigned m, int unsigned d,
                                         int unsigned h, int unsigned w);
    in_item_t it;
    it.in_year    = y[YEAR_W-1:0];
    it.in_month   = m[MONTH_W-1:0];
    it.in_day     = d[DAY_W-1:0];
    it.in_hour    = h[HOUR_W-1:0];
    it.in_weekday = w[WDAY_W-1:0];
    return it;
  endfunction

  function automatic in_item_t rand_date();
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned h;
    case ($urandom_range(0, 5))
      0: y = $urandom_range(0, 65535);
      1: y = YEAR_FLOOR;
      2: y = $urandom_range(1999, 2001);
      3: y = 65535;
      4: y = $urandom_range(1990, 2110);
      default: y = 400 * $urandom_range(0, 163) + 100 * $urandom_range(0, 3);
    endcase
    m = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
    case ($urandom_range(0, 3))
      0: d = $urandom_range(0, 1);
      1: d = $urandom_range(28, 31);
      2: d = $urandom_range(0, 31);
      default: d = $urandom_range(1, 28);
    endcase
    case ($urandom_range(0, 3))
      0: h = $urandom_range(0, 31);
      1: h = $urandom_range(0, 3);
      2: h = $urandom_range(20, 23);
      default: h = $urandom_range(0, 23);
    endcase
    return make_date(y, m, d, h, $urandom_range(0, 7));
  endfunction

  task automatic send_date(in_item_t it);
    start   = 1'b1;
    in_data = it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic idle_burst();
    start   = 1'b0;
    in_data = in_item_t'({$urandom, $urandom});
    repeat ($urandom_range(1, 11)) @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (sb.expected_dates.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_offset(logic signed [OFS_W-1:0] v);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_offset(v);
    @(negedge clk);
  endtask

  task automatic random_phase(logic signed [OFS_W-1:0] v, int count, bit allow_idle,
                              int pause_at);
    set_offset(v);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain();
      if (allow_idle && $urandom_range(0, 3) == 0) idle_burst();
      send_date(rand_date());
    end
  endtask

  initial begin
    logic signed [OFS_W-1:0] phase_offsets[9];
    sb          = new();
    cycle_count = 0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    start       = 1'b0;
    in_data     = '0;
    phase_offsets = '{-5'sd12, 5'sd14, 5'sd0, -5'sd16, 5'sd15, -5'sd1, 5'sd1,
                      5'($urandom_range(0, 31)), 5'($urandom_range(0, 31))};
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset offset of zero, then hour 24 (one past the hour range) and hour 0
    send_date(make_date(2020, 12, 31, 24, 2));
    send_date(make_date(2020, 6, 15, 0, 0));

    set_offset(-5'sd12);
    send_date(make_date(2000, 1, 1, 5, 3));
    send_date(make_date(1999, 0, 0, 2, 0));
    send_date(make_date(0, 0, 0, 0, 0));
    send_date(make_date(2001, 1, 1, 0, 1));
    send_date(make_date(2000, 3, 1, 11, 7));
    send_date(make_date(1900, 3, 1, 4, 2));
    send_date(make_date(2000, 13, 1, 0, 4));
    send_date(make_date(2023, 0, 0, 3, 5));
    send_date(make_date(2023, 7, 15, 12, 0));
    send_date(make_date(65535, 15, 31, 31, 7));

    set_offset(5'sd14);
    send_date(make_date(65535, 12, 31, 23, 7));
    send_date(make_date(2024, 2, 28, 20, 3));
    send_date(make_date(2023, 2, 28, 10, 6));
    send_date(make_date(2100, 2, 28, 10, 1));
    send_date(make_date(2023, 0, 30, 12, 0));
    send_date(make_date(2023, 15, 30, 12, 4));
    send_date(make_date(2023, 14, 29, 22, 5));
    send_date(make_date(2023, 4, 30, 15, 2));
    send_date(make_date(2023, 4, 31, 15, 2));
    send_date(make_date(2023, 6, 0, 9, 3));
    send_date(make_date(2023, 1, 31, 31, 7));

    set_offset(5'sd15);
    send_date(make_date(2020, 5, 5, 31, 6));
    set_offset(-5'sd16);
    send_date(make_date(2020, 5, 5, 0, 1));

    for (int p = 0; p < 9; p++) begin
      random_phase(phase_offsets[p], 90, p != 8, (p == 1) ? 45 : -1);
    end

    drain();
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.expected_dates.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/tzadj_pkg.sv
rtl/core/timezone_offset_date_adjust.sv
rtl/core/tzadj_checker.sv
verif/tb_top.sv
